/* design/mtsf_pkg.sv */
// ----------------------------------------------------------------------------
// mtsf_pkg
// Shared types and constants for the MT19937 first-four-words seeding block.
// ----------------------------------------------------------------------------
package mtsf_pkg;

  // Word width of the generator
  localparam int unsigned WordW = 32;

  // Initialization recurrence
  localparam logic [WordW-1:0] InitMult = 32'd1812433253;
  localparam int unsigned      LastWord = 400;
  localparam int unsigned      FarOffset = 397;
  localparam int unsigned      NumOut    = 4;

  // Step counter holds 0..LastWord
  localparam int unsigned CntW = $clog2(LastWord + 1);

  // Twist constants
  localparam logic [WordW-1:0] TwistMat  = 32'h9908_B0DF;
  localparam logic [WordW-1:0] UpperBit  = 32'h8000_0000;
  localparam logic [WordW-1:0] LowerBits = 32'h7FFF_FFFF;

  // Tempering masks
  localparam logic [WordW-1:0] TemperB = 32'h9d2c_5680;
  localparam logic [WordW-1:0] TemperC = 32'hefc6_0000;

  // Input transfer payload
  typedef struct packed {
    logic [WordW-1:0] seed_low;
    logic [WordW-1:0] base_offset;
  } in_t;

  // Result transfer payload
  typedef struct packed {
    logic [WordW-1:0] word0;
    logic [WordW-1:0] word1;
    logic [WordW-1:0] word2;
    logic [WordW-1:0] word3;
  } out_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_INIT = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

endpackage

/* design/mtsf_twist.sv */
// ----------------------------------------------------------------------------
// mtsf_twist
// Twists one state word against its neighbor and far word, then tempers it.
// ----------------------------------------------------------------------------
module mtsf_twist (
  input  logic [mtsf_pkg::WordW-1:0] w_cur,
  input  logic [mtsf_pkg::WordW-1:0] w_next,
  input  logic [mtsf_pkg::WordW-1:0] w_far,
  output logic [mtsf_pkg::WordW-1:0] word
);

  logic [mtsf_pkg::WordW-1:0] y;
  logic [mtsf_pkg::WordW-1:0] mag;
  logic [mtsf_pkg::WordW-1:0] t0;
  logic [mtsf_pkg::WordW-1:0] t1;
  logic [mtsf_pkg::WordW-1:0] t2;
  logic [mtsf_pkg::WordW-1:0] t3;

  // Twist: top bit of current word, low bits of the next
  assign y   = (w_cur & mtsf_pkg::UpperBit) | (w_next & mtsf_pkg::LowerBits);
  assign mag = y[0] ? mtsf_pkg::TwistMat : '0;
  assign t0  = w_far ^ (y >> 1) ^ mag;

  // Tempering
  assign t1   = t0 ^ (t0 >> 11);
  assign t2   = t1 ^ ((t1 << 7) & mtsf_pkg::TemperB);
  assign t3   = t2 ^ ((t2 << 15) & mtsf_pkg::TemperC);
  assign word = t3 ^ (t3 >> 18);

endmodule

/* design/mt19937_seed_first_four_words.sv */
// ----------------------------------------------------------------------------
// mt19937_seed_first_four_words
// Seeds a 32-bit Mersenne Twister and returns its first four tempered outputs.
// ----------------------------------------------------------------------------
// On its transfer an item's seed sum is loaded as state word 0; the
// initialization recurrence then runs through state words 1..400 on a single
// 32x32 multiplier (one state word per cycle, each depending on the one
// before). A finishing step, which waits while an earlier result still sits
// stalled in the output register, then twists and tempers the four output
// words into that register. The input stalls from the transfer until that
// finishing step is done, so a new item is not taken before the last one has
// reached the output register. A finished result waits in that register, so the
// next item can be taken while the previous result is still held. Only state words
// 0..4 and 397..400 are kept, in two short shift lines.
module mt19937_seed_first_four_words (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mtsf_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output mtsf_pkg::out_t   out_data
);

  localparam int unsigned HeadN = mtsf_pkg::NumOut + 1;
  localparam int unsigned TailN = mtsf_pkg::LastWord - mtsf_pkg::FarOffset + 1;

  mtsf_pkg::state_t state_r, state_nxt;
  logic [mtsf_pkg::CntW-1:0]  cnt_r, cnt_nxt;
  logic [mtsf_pkg::WordW-1:0] w_r, w_nxt;
  logic [mtsf_pkg::WordW-1:0] head_r [HeadN];
  logic [mtsf_pkg::WordW-1:0] tail_r [TailN];
  logic                       out_valid_r, out_valid_nxt;
  mtsf_pkg::out_t             out_r;
  mtsf_pkg::out_t             res;

  logic [mtsf_pkg::WordW-1:0] mix;
  logic [mtsf_pkg::WordW-1:0] prod;
  logic [mtsf_pkg::WordW-1:0] twisted [mtsf_pkg::NumOut];
  logic in_xfer, out_xfer, load_out;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign load_out = (state_r == mtsf_pkg::ST_FIN) && (!out_valid_r || !out_stall);

  assign in_stall  = (state_r != mtsf_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Shared multiplier: one recurrence step per cycle
  assign mix   = w_r ^ (w_r >> 30);
  assign prod  = mtsf_pkg::InitMult * mix;
  assign w_nxt = prod + {{(mtsf_pkg::WordW - mtsf_pkg::CntW){1'b0}}, cnt_r};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      mtsf_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = mtsf_pkg::ST_INIT;
          cnt_nxt   = mtsf_pkg::CntW'(1);
        end
      end
      mtsf_pkg::ST_INIT: begin
        if (cnt_r == mtsf_pkg::CntW'(mtsf_pkg::LastWord)) begin
          state_nxt = mtsf_pkg::ST_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      mtsf_pkg::ST_FIN: begin
        if (load_out) begin
          state_nxt     = mtsf_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = mtsf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mtsf_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Running state word and the two capture lines
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      w_r                <= in_data.seed_low + in_data.base_offset;
      head_r[HeadN-1]    <= in_data.seed_low + in_data.base_offset;
    end else if (state_r == mtsf_pkg::ST_INIT) begin
      w_r <= w_nxt;
      if (cnt_r <= mtsf_pkg::CntW'(mtsf_pkg::NumOut)) begin
        for (int k = 0; k < HeadN - 1; k++) begin
          head_r[k] <= head_r[k+1];
        end
        head_r[HeadN-1] <= w_nxt;
      end
      if (cnt_r >= mtsf_pkg::CntW'(mtsf_pkg::FarOffset)) begin
        for (int k = 0; k < TailN - 1; k++) begin
          tail_r[k] <= tail_r[k+1];
        end
        tail_r[TailN-1] <= w_nxt;
      end
    end
  end

  // Twist and temper the four output words
  for (genvar g = 0; g < mtsf_pkg::NumOut; g++) begin : g_twist
    mtsf_twist u_twist (
      .w_cur  (head_r[g]),
      .w_next (head_r[g+1]),
      .w_far  (tail_r[g]),
      .word   (twisted[g])
    );
  end

  always_comb begin
    res.word0 = twisted[0];
    res.word1 = twisted[1];
    res.word2 = twisted[2];
    res.word3 = twisted[3];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r <= res;
    end
  end

  // Assertions
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == mtsf_pkg::ST_INIT) && (cnt_r == mtsf_pkg::CntW'(1)))
    else $error("recurrence did not start at step one");

  a_init_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtsf_pkg::ST_INIT) |->
      (cnt_r >= mtsf_pkg::CntW'(1)) && (cnt_r <= mtsf_pkg::CntW'(mtsf_pkg::LastWord)))
    else $error("step counter out of range");

  a_fin_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mtsf_pkg::ST_FIN) |-> (cnt_r == mtsf_pkg::CntW'(mtsf_pkg::LastWord)))
    else $error("finish reached before the last state word");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == mtsf_pkg::ST_FIN))
    else $error("result raised outside the finish step");

endmodule
